@@ src/rau_pkg.sv @@
`timescale 1ns / 1ps
// rau_pkg: shared constants for the rational arithmetic unit
// operation kinds, status codes and default operand width; no dependencies
`default_nettype none

package rau_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;

	localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MUL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RED = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_ZERO_DEN = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_OVF      = 2'd2;

endpackage

`default_nettype wire

@@ src/rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// rational_arithmetic_unit: add, multiply and gcd-reduce of signed fractions
// uses rau_pkg for operation kinds, status codes and the default width
//
// Usage: an item enters on the s_ channel (tuser = operation, tdata = the two
// fractions) and one result item leaves on the m_ channel (tuser = status,
// tdata = result fraction). s_tready is high only while the unit is idle, so
// one item is in work at a time. Products, gcd subtractions and division steps
// all run through a single shared adder/subtractor of 2*WIDTH+2 bits under a
// small sequencer:
//   add       three shift-add products, one bit a cycle
//   multiply  two shift-add products
//   reduce    binary gcd steps (at most about 4*WIDTH), then two restoring
//             divisions
//   zero input denominator: straight from the start step to the result
// Results go to an output register; a new item is taken while a result still
// waits there. If the next result is done before the receiver takes the
// previous one, the unit holds it and stays busy until m_tready.
// Reset (arst_n low) returns the sequencer to idle and empties the output.
`default_nettype none

module rational_arithmetic_unit #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// a_num, a_den, b_num, b_den, zero pad
	input  wire logic [((4*WIDTH+7)/8)*8-1:0]           s_tdata,
	// kind
	input  wire logic [rau_pkg::KIND_W-1:0]             s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// res_num, res_den, zero pad
	output logic [((2*WIDTH+7)/8)*8-1:0]                m_tdata,
	// status
	output logic [rau_pkg::STATUS_W-1:0]                m_tuser
);

	localparam int PW       = 2 * WIDTH + 2;
	localparam int CW       = $clog2(WIDTH);
	localparam int OUT_BITS = ((2 * WIDTH + 7) / 8) * 8;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_GCD   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	localparam logic [1:0] PH_P0 = 2'd0;
	localparam logic [1:0] PH_P1 = 2'd1;
	localparam logic [1:0] PH_P2 = 2'd2;

	logic [2:0]                   state_q;
	logic [rau_pkg::KIND_W-1:0]   kind_q;
	logic [WIDTH-1:0]             an_q, ad_q, bn_q, bd_q;
	logic [PW-1:0]                acc_q, mc_q, num_q;
	logic [WIDTH-1:0]             mp_q;
	logic                         neg_q;
	logic [CW-1:0]                cnt_q;
	logic [1:0]                   phase_q;
	logic                         zero_q;
	logic [WIDTH-1:0]             u_q, v_q, g_q, rem_q, dvd_q, qn_q;
	logic [CW-1:0]                k_q;
	logic                         m_tvalid_q;
	logic [WIDTH-1:0]             res_num_q, res_den_q;
	logic [rau_pkg::STATUS_W-1:0] status_q;

	logic             arith;
	logic [WIDTH-1:0] an_mag, ad_mag, bn_mag, bd_mag;
	logic [1:0]       ld_phase;
	logic [WIDTH-1:0] ld_x, ld_y;
	logic             ld_neg;
	logic [PW-1:0]    alu_a, alu_b, alu_y;
	logic             alu_sub;
	logic [PW-1:0]    acc_nx;
	logic             last_bit;
	logic [WIDTH:0]   div_sh;
	logic             div_bit;
	logic [WIDTH-1:0] rem_nx, dvd_nx;
	logic             out_free;
	logic             num_fits, den_fits;
	logic [WIDTH-1:0] fin_num, fin_den;
	logic [rau_pkg::STATUS_W-1:0] fin_status;

	assign arith = (kind_q == rau_pkg::KIND_ADD) || (kind_q == rau_pkg::KIND_MUL);

	assign an_mag = an_q[WIDTH-1] ? (~an_q + WIDTH'(1)) : an_q;
	assign ad_mag = ad_q[WIDTH-1] ? (~ad_q + WIDTH'(1)) : ad_q;
	assign bn_mag = bn_q[WIDTH-1] ? (~bn_q + WIDTH'(1)) : bn_q;
	assign bd_mag = bd_q[WIDTH-1] ? (~bd_q + WIDTH'(1)) : bd_q;

	// operand selection for the next product
	always_comb begin
		if (state_q == S_START) begin
			ld_phase = PH_P0;
		end else if (phase_q == PH_P0 && kind_q == rau_pkg::KIND_ADD) begin
			ld_phase = PH_P1;
		end else begin
			ld_phase = PH_P2;
		end
		case (ld_phase)
			PH_P0: begin
				ld_x   = an_mag;
				ld_y   = (kind_q == rau_pkg::KIND_ADD) ? bd_mag : bn_mag;
				ld_neg = an_q[WIDTH-1] ^
					((kind_q == rau_pkg::KIND_ADD) ? bd_q[WIDTH-1] : bn_q[WIDTH-1]);
			end
			PH_P1: begin
				ld_x   = bn_mag;
				ld_y   = ad_mag;
				ld_neg = bn_q[WIDTH-1] ^ ad_q[WIDTH-1];
			end
			default: begin
				ld_x   = ad_mag;
				ld_y   = bd_mag;
				ld_neg = ad_q[WIDTH-1] ^ bd_q[WIDTH-1];
			end
		endcase
	end

	// shared adder/subtractor
	assign div_sh = {rem_q, dvd_q[WIDTH-1]};

	always_comb begin
		unique case (state_q)
			S_GCD: begin
				alu_a   = PW'(u_q);
				alu_b   = PW'(v_q);
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_a   = PW'(div_sh);
				alu_b   = PW'(g_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = acc_q;
				alu_b   = mc_q;
				alu_sub = neg_q;
			end
		endcase
	end

	assign alu_y = alu_a + (alu_b ^ {PW{alu_sub}}) + PW'(alu_sub);

	assign acc_nx   = mp_q[0] ? alu_y : acc_q;
	assign last_bit = (cnt_q == CW'(WIDTH - 1));

	assign div_bit = ~alu_y[PW-1];
	assign rem_nx  = div_bit ? alu_y[WIDTH-1:0] : div_sh[WIDTH-1:0];
	assign dvd_nx  = {dvd_q[WIDTH-2:0], div_bit};

	// result formatting
	assign num_fits = (&num_q[PW-1:WIDTH-1]) || ~(|num_q[PW-1:WIDTH-1]);
	assign den_fits = (&acc_q[PW-1:WIDTH-1]) || ~(|acc_q[PW-1:WIDTH-1]);

	always_comb begin
		if (zero_q) begin
			fin_num    = '0;
			fin_den    = '0;
			fin_status = rau_pkg::STAT_ZERO_DEN;
		end else if (arith) begin
			if (acc_q[WIDTH-1:0] == '0) begin
				fin_num    = '0;
				fin_den    = '0;
				fin_status = rau_pkg::STAT_ZERO_DEN;
			end else begin
				fin_num    = num_q[WIDTH-1:0];
				fin_den    = acc_q[WIDTH-1:0];
				fin_status = (num_fits && den_fits) ? rau_pkg::STAT_OK : rau_pkg::STAT_OVF;
			end
		end else begin
			fin_num    = an_q[WIDTH-1] ? (~qn_q + WIDTH'(1)) : qn_q;
			fin_den    = ad_q[WIDTH-1] ? (~dvd_q + WIDTH'(1)) : dvd_q;
			fin_status = g_q[WIDTH-1] ? rau_pkg::STAT_OVF : rau_pkg::STAT_OK;
		end
	end

	assign out_free = ~m_tvalid_q | m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (arith) begin
						state_q <= (ad_q == '0 || bd_q == '0) ? S_FIN : S_MUL;
					end else begin
						state_q <= (ad_q == '0) ? S_FIN : S_GCD;
					end
				end
				S_MUL: begin
					if (last_bit && phase_q == PH_P2) begin
						state_q <= S_FIN;
					end
				end
				S_GCD: begin
					if (v_q == '0) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (last_bit && phase_q != PH_P0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					kind_q <= s_tuser;
					an_q   <= s_tdata[WIDTH-1:0];
					ad_q   <= s_tdata[2*WIDTH-1:WIDTH];
					bn_q   <= s_tdata[3*WIDTH-1:2*WIDTH];
					bd_q   <= s_tdata[4*WIDTH-1:3*WIDTH];
				end
			end
			S_START: begin
				zero_q  <= arith ? (ad_q == '0 || bd_q == '0) : (ad_q == '0);
				acc_q   <= '0;
				mc_q    <= PW'(ld_x);
				mp_q    <= ld_y;
				neg_q   <= ld_neg;
				cnt_q   <= '0;
				phase_q <= PH_P0;
				u_q     <= ad_mag;
				v_q     <= an_mag;
				k_q     <= '0;
			end
			S_MUL: begin
				if (last_bit) begin
					cnt_q   <= '0;
					phase_q <= ld_phase;
					mc_q    <= PW'(ld_x);
					mp_q    <= ld_y;
					neg_q   <= ld_neg;
					if (ld_phase == PH_P2 && phase_q != PH_P2) begin
						num_q <= acc_nx;
						acc_q <= '0;
					end else begin
						acc_q <= acc_nx;
					end
				end else begin
					cnt_q <= cnt_q + CW'(1);
					mc_q  <= {mc_q[PW-2:0], 1'b0};
					mp_q  <= {1'b0, mp_q[WIDTH-1:1]};
					acc_q <= acc_nx;
				end
			end
			S_GCD: begin
				if (v_q == '0) begin
					g_q     <= u_q << k_q;
					rem_q   <= '0;
					dvd_q   <= an_mag;
					cnt_q   <= '0;
					phase_q <= PH_P0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + CW'(1);
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (alu_y[PW-1]) begin
					v_q <= ~alu_y[WIDTH-1:0] + WIDTH'(1);
				end else begin
					u_q <= v_q;
					v_q <= alu_y[WIDTH-1:0];
				end
			end
			S_DIV: begin
				if (last_bit && phase_q == PH_P0) begin
					qn_q    <= dvd_nx;
					rem_q   <= '0;
					dvd_q   <= ad_mag;
					cnt_q   <= '0;
					phase_q <= PH_P1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
					rem_q <= rem_nx;
					dvd_q <= dvd_nx;
				end
			end
			S_FIN: begin
				if (out_free) begin
					res_num_q <= fin_num;
					res_den_q <= fin_den;
					status_q  <= fin_status;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_BITS'({res_den_q, res_num_q});
	assign m_tuser  = status_q;

endmodule

`default_nettype wire
